[rtl/ssd_pkg.sv]
package ssd_pkg;

    localparam int NUM_DIGITS = 4;
    localparam int VALUE_W    = 16;
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int CNT_W      = $clog2(VALUE_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_W - 1);

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_SHOW = 1'b1;

    typedef struct packed {
        logic               command;
        logic [VALUE_W-1:0] value;
        logic [1:0]         position;
    } ssd_in_t;

    typedef struct packed {
        logic [6:0] segments;
        logic [3:0] digit_enables;
    } ssd_out_t;

    typedef struct packed {
        logic start_load;
        logic shift;
        logic show;
    } ssd_cmd_t;

    typedef struct packed {
        logic count_last;
    } ssd_stat_t;

    // gfedcba, codes above nine are blank
    function automatic logic [6:0] seg_pattern(input logic [3:0] digit);
        logic [6:0] seg;
        case (digit)
            4'd0:    seg = 7'h3F;
            4'd1:    seg = 7'h06;
            4'd2:    seg = 7'h5B;
            4'd3:    seg = 7'h4F;
            4'd4:    seg = 7'h66;
            4'd5:    seg = 7'h6D;
            4'd6:    seg = 7'h7D;
            4'd7:    seg = 7'h07;
            4'd8:    seg = 7'h7F;
            4'd9:    seg = 7'h6F;
            default: seg = 7'h00;
        endcase
        return seg;
    endfunction

endpackage

[rtl/seven_segment_decimal_display_top.sv]
// Channel  Signals                            Word
// item     item_valid, item_stall, item       ssd_in_t  {command, value, position}
// result   result_valid, result_stall, result ssd_out_t {segments, digit_enables}
//
// A show's result word appears the cycle after acceptance.
// A load runs a double-dabble shift loop, one bit a cycle, before the
// next item is taken. It produces no result word.
// Reset clears the digit store to zeros and empties the result register.
// A waiting result word stalls new items; a load in progress stalls new items.
module seven_segment_decimal_display_top (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  ssd_pkg::ssd_in_t item,
    output logic             result_valid,
    input  logic             result_stall,
    output ssd_pkg::ssd_out_t result
);
    import ssd_pkg::*;

    ssd_cmd_t  cmd;
    ssd_stat_t stat;

    ssd_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .command      (item.command),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .stat         (stat),
        .cmd          (cmd)
    );

    ssd_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .stat   (stat),
        .result (result)
    );

endmodule

[rtl/ssd_datapath.sv]
module ssd_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  ssd_pkg::ssd_in_t  item,
    input  ssd_pkg::ssd_cmd_t cmd,
    output ssd_pkg::ssd_stat_t stat,
    output ssd_pkg::ssd_out_t result
);
    import ssd_pkg::*;

    logic [VALUE_W-1:0] bin_reg;
    logic [BCD_W-1:0]   bcd_reg;
    logic [BCD_W-1:0]   bcd_adj;
    logic [BCD_W-1:0]   bcd_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [3:0]         store_reg [NUM_DIGITS];
    ssd_out_t           result_reg;
    ssd_out_t           result_next;
    logic [3:0]         sel_digit;
    logic               sel_hit;

    // add three to every digit of five or more, then shift in the next binary bit
    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            else
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
        end
        bcd_next = {bcd_adj[BCD_W-2:0], bin_reg[VALUE_W-1]};
    end

    assign stat.count_last = (cnt_reg == CNT_LAST);

    always_ff @(posedge clk)
    begin
        if (cmd.start_load)
        begin
            bin_reg <= item.value;
            bcd_reg <= '0;
        end
        else if (cmd.shift)
        begin
            bin_reg <= {bin_reg[VALUE_W-2:0], 1'b0};
            bcd_reg <= bcd_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (cmd.start_load)
            cnt_reg <= '0;
        else if (cmd.shift)
            cnt_reg <= cnt_reg + 1'b1;
    end

    // commit on the last shift; position 0 takes the most significant digit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_DIGITS; i++)
                store_reg[i] <= 4'd0;
        end
        else if (cmd.shift && stat.count_last)
        begin
            for (int i = 0; i < NUM_DIGITS; i++)
                store_reg[i] <= bcd_next[4*(NUM_DIGITS-1-i) +: 4];
        end
    end

    always_comb
    begin
        sel_digit = 4'd0;
        sel_hit   = 1'b0;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if ({1'b0, item.position} == 3'(i))
            begin
                sel_digit = store_reg[i];
                sel_hit   = 1'b1;
            end
        end
        result_next.segments      = sel_hit ? seg_pattern(sel_digit) : 7'h00;
        result_next.digit_enables = ~(4'b0001 << item.position);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.show)
            result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

[rtl/ssd_ctrl.sv]
module ssd_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  logic               command,
    output logic               result_valid,
    input  logic               result_stall,
    input  ssd_pkg::ssd_stat_t stat,
    output ssd_pkg::ssd_cmd_t  cmd
);
    import ssd_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_CONV
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;

    // hold input while converting or while the result word is still waiting
    assign item_stall = (state_reg == ST_CONV) || (out_valid_reg && result_stall);
    assign accept     = item_valid && !item_stall;

    always_comb
    begin
        cmd.start_load = accept && (command == CMD_LOAD);
        cmd.show       = accept && (command == CMD_SHOW);
        cmd.shift      = (state_reg == ST_CONV);

        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (cmd.start_load)
                    state_next = ST_CONV;
            ST_CONV:
                if (stat.count_last)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase

        out_valid_next = out_valid_reg;
        if (cmd.show)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !result_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result_valid = out_valid_reg;

    a_load_starts_conv: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start_load |=> (state_reg == ST_CONV))
        else $error("load did not start conversion");

    a_conv_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CONV) && stat.count_last |=> (state_reg == ST_IDLE))
        else $error("conversion did not end after the last shift");

    a_show_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.show |=> result_valid)
        else $error("show produced no result word");

endmodule
